// File: design/bfha_pkg.sv
// shared constants, block table entry type and cell command codes
// for the best-fit heap allocator; no dependencies
package bfha_pkg;

  localparam int MAX_BLOCKS    = 64;
  localparam int HEADER_BYTES  = 16;
  localparam int MIN_REMAINDER = 16;
  localparam int ALIGN_BYTES   = 4;
  localparam int PAGE_BYTES    = 4096;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef struct packed {
    logic        valid;
    logic        free;
    logic [31:0] off;
    logic [31:0] size;
  } entry_t;

  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_ROT  = 3'd1;
  localparam logic [2:0] OP_DEL  = 3'd2;
  localparam logic [2:0] OP_INS  = 3'd3;
  localparam logic [2:0] OP_WR   = 3'd4;
  localparam logic [2:0] OP_INIT = 3'd5;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } cell_cmd_t;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_NOOP    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

endpackage

// File: design/bfha_if.sv
// request and result channel interfaces of the heap allocator
// depends on nothing
interface bfha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] req_size;
  logic [31:0] req_addr;
  modport source(output valid, req_type, req_size, req_addr, input ready);
  modport sink(input valid, req_type, req_size, req_addr, output ready);
endinterface

interface bfha_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_addr;
  logic        copy_needed;
  logic [31:0] copy_len;
  modport source(output valid, status, result_addr, copy_needed, copy_len, input ready);
  modport sink(input valid, status, result_addr, copy_needed, copy_len, output ready);
endinterface

// File: design/bfha_cell.sv
// one entry of the block table chain: rotate, shift, insert, write and init
// depends on bfha_pkg
module bfha_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [bfha_pkg::IDX_W-1:0] pos,
  input  bfha_pkg::cell_cmd_t      cmd,
  input  bfha_pkg::entry_t         left,
  input  bfha_pkg::entry_t         right,
  output bfha_pkg::entry_t         ent
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= (pos == '0);
      ent.free  <= 1'b1;
      ent.off   <= '0;
      ent.size  <= '0;
    end else begin
      unique case (cmd.op)
        bfha_pkg::OP_ROT: ent <= right;
        bfha_pkg::OP_DEL: begin
          if (pos >= cmd.idx) ent <= right;
        end
        bfha_pkg::OP_INS: begin
          if (pos > cmd.idx) ent <= left;
          else if (pos == cmd.idx) ent <= cmd.data;
        end
        bfha_pkg::OP_WR: begin
          if (pos == cmd.idx) ent <= cmd.data;
        end
        bfha_pkg::OP_INIT: ent <= (pos == '0) ? cmd.data : '0;
        default: ent <= ent;
      endcase
    end
  end

endmodule

// File: design/bfha_ctrl.sv
// request sequencer: scan passes over the rotating cell chain,
// table edits, configuration and result register; depends on bfha_pkg, bfha_if
module bfha_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  bfha_req_if.sink             req,
  bfha_res_if.source           res,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [31:0]          cfg_data,
  input  bfha_pkg::entry_t     head,
  output bfha_pkg::cell_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_REL0 = 4'd3;
  localparam logic [3:0] S_REL1 = 4'd4;
  localparam logic [3:0] S_REL2 = 4'd5;
  localparam logic [3:0] S_REL3 = 4'd6;
  localparam logic [3:0] S_AL1  = 4'd7;
  localparam logic [3:0] S_AL2  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  localparam logic [1:0] MODE_ADDR = 2'd0;
  localparam logic [1:0] MODE_FIT  = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  localparam int          IW     = bfha_pkg::IDX_W;
  localparam int          CW     = bfha_pkg::CNT_W;
  localparam logic [31:0] HDR    = 32'(bfha_pkg::HEADER_BYTES);
  localparam logic [31:0] PMASK  = 32'(bfha_pkg::PAGE_BYTES - 1);
  localparam logic [32:0] AL_ADD = 33'(bfha_pkg::ALIGN_BYTES - 1);
  localparam logic [33:0] SPLIT_MIN = 34'(bfha_pkg::HEADER_BYTES + bfha_pkg::MIN_REMAINDER);
  localparam logic [IW-1:0] LAST = IW'(bfha_pkg::MAX_BLOCKS - 1);
  localparam logic [CW-1:0] FULL = CW'(bfha_pkg::MAX_BLOCKS);

  logic [3:0]  state;
  logic [1:0]  mode;
  logic [1:0]  rtype;
  logic [31:0] rsize;
  logic [31:0] key;
  logic [32:0] need;
  logic        mv;
  logic [CW-1:0] cnt;
  logic [IW-1:0] i;
  logic [31:0] ps_h;

  logic        hit;
  logic        want_nxt;
  logic [IW-1:0] hit_idx;
  bfha_pkg::entry_t tgt, prv, nxt, last;

  logic        best_ok;
  logic        exact;
  logic [IW-1:0] best_idx;
  bfha_pkg::entry_t best;

  logic [31:0] old_off;
  logic [31:0] old_size;
  logic [31:0] s1;

  logic [1:0]  r_status;
  logic [31:0] r_addr;
  logic        r_cneed;
  logic [31:0] r_clen;

  logic        o_valid;
  logic [1:0]  o_status;
  logic [31:0] o_addr;
  logic        o_cneed;
  logic [31:0] o_clen;

  logic        scan_match;
  logic        fit_ok;
  logic        split;
  logic        nf;
  logic        pf;
  logic [32:0] need_w;
  logic [31:0] page_w;

  assign req.ready       = (state == S_IDLE);
  assign res.valid       = o_valid;
  assign res.status      = o_status;
  assign res.result_addr = o_addr;
  assign res.copy_needed = o_cneed;
  assign res.copy_len    = o_clen;

  assign need_w = ({1'b0, req.req_size} + AL_ADD) / bfha_pkg::ALIGN_BYTES
                  * bfha_pkg::ALIGN_BYTES;
  assign page_w = (cfg_data + PMASK) & ~PMASK;

  assign scan_match = head.valid &&
    ((mode == MODE_OFF) ? (head.off == old_off)
                        : (mode == MODE_ADDR && !head.free && (ps_h + head.off) == key));
  assign fit_ok = head.valid && head.free && ({1'b0, head.size} >= need);
  assign split  = ({2'b0, best.size} > ({1'b0, need} + SPLIT_MIN)) && (cnt < FULL);
  assign nf     = nxt.valid && nxt.free;
  assign pf     = prv.valid && prv.free;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_SCAN: cmd.op = bfha_pkg::OP_ROT;
      S_AL1: begin
        cmd.op         = bfha_pkg::OP_WR;
        cmd.idx        = best_idx;
        cmd.data.valid = 1'b1;
        cmd.data.free  = 1'b0;
        cmd.data.off   = best.off;
        cmd.data.size  = split ? need[31:0] : best.size;
      end
      S_AL2: begin
        cmd.op         = bfha_pkg::OP_INS;
        cmd.idx        = best_idx + IW'(1);
        cmd.data.valid = 1'b1;
        cmd.data.free  = 1'b1;
        cmd.data.off   = best.off + HDR + need[31:0];
        cmd.data.size  = best.size - need[31:0] - HDR;
      end
      S_REL1: begin
        cmd.op         = bfha_pkg::OP_WR;
        cmd.idx        = pf ? hit_idx - IW'(1) : hit_idx;
        cmd.data.valid = 1'b1;
        cmd.data.free  = 1'b1;
        cmd.data.off   = pf ? prv.off : tgt.off;
        cmd.data.size  = pf ? prv.size + s1 + HDR : s1;
      end
      S_REL2: begin
        cmd.op  = pf ? bfha_pkg::OP_DEL : bfha_pkg::OP_HOLD;
        cmd.idx = hit_idx;
      end
      S_REL3: begin
        cmd.op  = nf ? bfha_pkg::OP_DEL : bfha_pkg::OP_HOLD;
        cmd.idx = pf ? hit_idx : hit_idx + IW'(1);
      end
      default: cmd = '0;
    endcase
    if (cfg_we && cfg_idx == bfha_pkg::CFG_BYTES) begin
      cmd.op         = bfha_pkg::OP_INIT;
      cmd.idx        = '0;
      cmd.data.valid = 1'b1;
      cmd.data.free  = 1'b1;
      cmd.data.off   = '0;
      cmd.data.size  = (cfg_data > HDR) ? cfg_data - HDR : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      cnt     <= CW'(1);
      ps_h    <= HDR;
      i       <= '0;
      hit     <= 1'b0;
      want_nxt <= 1'b0;
      best_ok <= 1'b0;
      exact   <= 1'b0;
      mv      <= 1'b0;
      mode    <= MODE_ADDR;
    end else begin
      if (res.valid && res.ready && state != S_FIN) o_valid <= 1'b0;

      if (cfg_we) begin
        if (cfg_idx == bfha_pkg::CFG_BASE) ps_h <= page_w + HDR;
        else cnt <= CW'(1);
      end

      unique case (state)
        S_IDLE: begin
          hit       <= 1'b0;
          want_nxt  <= 1'b0;
          best_ok   <= 1'b0;
          exact     <= 1'b0;
          nxt.valid <= 1'b0;
          last.valid <= 1'b0;
          i         <= '0;
          if (req.valid) begin
            rtype    <= req.req_type;
            rsize    <= req.req_size;
            key      <= req.req_addr;
            need     <= need_w;
            mv       <= 1'b0;
            r_status <= bfha_pkg::ST_NOOP;
            r_addr   <= '0;
            r_cneed  <= 1'b0;
            r_clen   <= '0;
            unique case (req.req_type)
              bfha_pkg::REQ_ALLOC: begin
                if (req.req_size != '0) begin
                  mode  <= MODE_FIT;
                  state <= S_SCAN;
                end else begin
                  state <= S_FIN;
                end
              end
              bfha_pkg::REQ_FREE: begin
                if (req.req_addr != '0) begin
                  mode  <= MODE_ADDR;
                  state <= S_SCAN;
                end else begin
                  state <= S_FIN;
                end
              end
              bfha_pkg::REQ_RESIZE: begin
                if (req.req_addr != '0) begin
                  mode  <= MODE_ADDR;
                  state <= S_SCAN;
                end else if (req.req_size != '0) begin
                  mode  <= MODE_FIT;
                  state <= S_SCAN;
                end else begin
                  state <= S_FIN;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_SCAN: begin
          if (want_nxt) begin
            nxt      <= head;
            want_nxt <= 1'b0;
          end
          if (scan_match && !hit) begin
            hit      <= 1'b1;
            hit_idx  <= i;
            tgt      <= head;
            prv      <= last;
            want_nxt <= 1'b1;
          end
          last <= head;
          if (mode == MODE_FIT && fit_ok && !exact && (!best_ok || head.size < best.size)) begin
            best_ok  <= 1'b1;
            best_idx <= i;
            best     <= head;
            exact    <= ({1'b0, head.size} == need);
          end
          if (i == LAST) begin
            i     <= '0;
            state <= S_EVAL;
          end else begin
            i <= i + IW'(1);
          end
        end
        S_EVAL: begin
          want_nxt <= 1'b0;
          unique case (mode)
            MODE_ADDR: begin
              if (!hit) begin
                r_status <= bfha_pkg::ST_UNKNOWN;
                state    <= S_FIN;
              end else if (rtype == bfha_pkg::REQ_FREE || rsize == '0) begin
                r_status <= bfha_pkg::ST_DONE;
                state    <= S_REL0;
              end else if (tgt.size >= rsize) begin
                r_status <= bfha_pkg::ST_NOOP;
                r_addr   <= key;
                state    <= S_FIN;
              end else begin
                old_off  <= tgt.off;
                old_size <= tgt.size;
                mv       <= 1'b1;
                mode     <= MODE_FIT;
                state    <= S_SCAN;
              end
            end
            MODE_FIT: begin
              if (!best_ok) begin
                r_status <= bfha_pkg::ST_OOM;
                r_addr   <= '0;
                state    <= S_FIN;
              end else begin
                state <= S_AL1;
              end
            end
            default: state <= hit ? S_REL0 : S_FIN;
          endcase
        end
        S_AL1: begin
          r_status <= bfha_pkg::ST_DONE;
          r_addr   <= ps_h + best.off;
          if (mv) begin
            r_cneed <= 1'b1;
            r_clen  <= old_size;
          end
          if (split) begin
            cnt   <= cnt + CW'(1);
            state <= S_AL2;
          end else if (mv) begin
            hit        <= 1'b0;
            nxt.valid  <= 1'b0;
            last.valid <= 1'b0;
            mode       <= MODE_OFF;
            state      <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_AL2: begin
          if (mv) begin
            hit        <= 1'b0;
            nxt.valid  <= 1'b0;
            last.valid <= 1'b0;
            mode       <= MODE_OFF;
            state      <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_REL0: begin
          s1    <= tgt.size + (nf ? nxt.size + HDR : '0);
          state <= S_REL1;
        end
        S_REL1: state <= S_REL2;
        S_REL2: begin
          if (pf) cnt <= cnt - CW'(1);
          state <= S_REL3;
        end
        S_REL3: begin
          if (nf) cnt <= cnt - CW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!o_valid || res.ready) begin
            o_valid  <= 1'b1;
            o_status <= r_status;
            o_addr   <= r_addr;
            o_cneed  <= r_cneed;
            o_clen   <= r_clen;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/best_fit_heap_allocator.sv
// Best-fit heap allocator with coalescing. The block table lives in a chain of
// 64 cells that rotates one entry per cycle past the sequencer while a scan runs,
// so every table search is one full pass of the chain; splits and merges are then
// shifts of the chain. A resize that moves its block makes three passes (find,
// best-fit search, find again). The request port reopens as the result register
// is loaded, and one request is in work at a time.
// Depends on bfha_pkg, bfha_if, bfha_cell, bfha_ctrl.
module best_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  bfha_req_if.sink    req,
  bfha_res_if.source  res,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data
);

  localparam int N = bfha_pkg::MAX_BLOCKS;

  bfha_pkg::entry_t    ents [N];
  bfha_pkg::cell_cmd_t cmd;
  bfha_pkg::entry_t    tail_in;

  assign tail_in = (cmd.op == bfha_pkg::OP_ROT) ? ents[0] : '0;

  bfha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .head     (ents[0]),
    .cmd      (cmd)
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    bfha_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .pos   (bfha_pkg::IDX_W'(k)),
      .cmd   (cmd),
      .left  ((k == 0) ? '0 : ents[(k == 0) ? 0 : k - 1]),
      .right ((k == N - 1) ? tail_in : ents[(k == N - 1) ? 0 : k + 1]),
      .ent   (ents[k])
    );
  end

endmodule

// File: bench/tb_best_fit_heap_allocator.sv
`timescale 1ns / 100ps
// self-checking bench for best_fit_heap_allocator: own block table model in a
// scoreboard class, directed cases and random request mix. depends on bfha_pkg, bfha_if and the rtl
import bfha_pkg::*;

typedef struct {
  logic [1:0]  status;
  logic [31:0] result_addr;
  logic        copy_needed;
  logic [31:0] copy_len;
} heap_reply_t;

class heap_scoreboard;
  logic [31:0] base_reg, bytes_reg;
  logic [31:0] offs[MAX_BLOCKS];
  logic [31:0] sizes[MAX_BLOCKS];
  bit          frees[MAX_BLOCKS];
  int          count;
  heap_reply_t replies[$];
  int          errors;

  function void clear_table();
    count = 1;
    offs[0] = 0;
    sizes[0] = (bytes_reg > HEADER_BYTES) ? bytes_reg - HEADER_BYTES : 0;
    frees[0] = 1;
  endfunction

  function void set_reg(bit idx, logic [31:0] val);
    if (idx == CFG_BASE) base_reg = val;
    else begin
      bytes_reg = val;
      clear_table();
    end
  endfunction

  function logic [31:0] payload(int i);
    logic [63:0] pg;
    pg = ({32'd0, base_reg} + 64'd4095) & ~64'd4095;
    return pg[31:0] + offs[i] + HEADER_BYTES;
  endfunction

  // payload of some allocated block (of any block when any_blk is set), or of any block when none is in use
  function logic [31:0] pick_addr(bit any_blk);
    int used[$];
    for (int i = 0; i < count; i++) if (any_blk || !frees[i]) used.push_back(i);
    if (used.size() == 0) return payload($urandom_range(count - 1));
    return payload(used[$urandom_range(used.size() - 1)]);
  endfunction

  function int find_used(logic [31:0] a);
    for (int i = 0; i < count; i++) if (!frees[i] && payload(i) == a) return i;
    return -1;
  endfunction

  function void drop(int i);
    for (int k = i; k + 1 < count; k++) begin
      offs[k] = offs[k+1];
      sizes[k] = sizes[k+1];
      frees[k] = frees[k+1];
    end
    count--;
  endfunction

  function void release_blk(int i);
    frees[i] = 1;
    if (i + 1 < count && frees[i+1]) begin
      sizes[i] = sizes[i] + sizes[i+1] + HEADER_BYTES;
      drop(i + 1);
    end
    if (i > 0 && frees[i-1]) begin
      sizes[i-1] = sizes[i-1] + sizes[i] + HEADER_BYTES;
      drop(i);
    end
  endfunction

  function logic [1:0] take_fit(logic [31:0] req, output logic [31:0] addr);
    longint need;
    int best;
    best = -1;
    addr = 0;
    if (req == 0) return ST_NOOP;
    need = ((longint'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    for (int i = 0; i < count; i++) begin
      if (frees[i] && longint'(sizes[i]) >= need &&
          (best < 0 || sizes[i] < sizes[best])) begin
        best = i;
        if (longint'(sizes[i]) == need) break;
      end
    end
    if (best < 0) return ST_OOM;
    if (longint'(sizes[best]) > need + HEADER_BYTES + MIN_REMAINDER && count < MAX_BLOCKS) begin
      for (int k = count; k > best + 1; k--) begin
        offs[k] = offs[k-1];
        sizes[k] = sizes[k-1];
        frees[k] = frees[k-1];
      end
      offs[best+1] = offs[best] + HEADER_BYTES + need[31:0];
      sizes[best+1] = sizes[best] - need[31:0] - HEADER_BYTES;
      frees[best+1] = 1;
      sizes[best] = need[31:0];
      count++;
    end
    frees[best] = 0;
    addr = payload(best);
    return ST_DONE;
  endfunction

  function void note_request(logic [1:0] kind, logic [31:0] sz, logic [31:0] a);
    heap_reply_t r;
    int idx;
    logic [31:0] old_off, old_size, na;
    r = '{ST_NOOP, 32'd0, 1'b0, 32'd0};
    if (kind == REQ_ALLOC) r.status = take_fit(sz, r.result_addr);
    else if (kind == REQ_FREE) begin
      if (a != 0) begin
        idx = find_used(a);
        if (idx < 0) r.status = ST_UNKNOWN;
        else begin
          release_blk(idx);
          r.status = ST_DONE;
        end
      end
    end else if (kind == REQ_RESIZE) begin
      if (a == 0) r.status = take_fit(sz, r.result_addr);
      else begin
        idx = find_used(a);
        if (idx < 0) r.status = ST_UNKNOWN;
        else if (sz == 0) begin
          release_blk(idx);
          r.status = ST_DONE;
        end else if (sizes[idx] >= sz) r.result_addr = a;
        else begin
          old_off = offs[idx];
          old_size = sizes[idx];
          if (take_fit(sz, na) != ST_DONE) r.status = ST_OOM;
          else begin
            for (int i = 0; i < count; i++)
              if (offs[i] == old_off) begin
                release_blk(i);
                break;
              end
            r = '{ST_DONE, na, 1'b1, old_size};
          end
        end
      end
    end
    replies.push_back(r);
  endfunction

  function void check_reply(logic [1:0] st, logic [31:0] ra, logic cn, logic [31:0] cl);
    heap_reply_t e;
    if (replies.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    e = replies.pop_front();
    if (st !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, st);
      errors++;
    end
    if (ra !== e.result_addr) begin
      $error("result_addr: expected %h, got %h", e.result_addr, ra);
      errors++;
    end
    if (cn !== e.copy_needed) begin
      $error("copy_needed: expected %0d, got %0d", e.copy_needed, cn);
      errors++;
    end
    if (cl !== e.copy_len) begin
      $error("copy_len: expected %h, got %h", e.copy_len, cl);
      errors++;
    end
  endfunction
endclass

module tb_best_fit_heap_allocator;
  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_idx = 0;
  logic [31:0] cfg_data = 0;
  bit quiet = 0;
  int hold_cycles = 0;
  heap_scoreboard sb = new();

  bfha_req_if req();
  bfha_res_if res();

  best_fit_heap_allocator uut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    req.valid = 0;
    req.req_type = 0;
    req.req_size = 0;
    req.req_addr = 0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_reply(res.status, res.result_addr, res.copy_needed, res.copy_len);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res.ready <= 0;
    end else
      res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);
  end

  task automatic send(logic [1:0] kind, logic [31:0] sz, logic [31:0] a);
    while (!quiet && $urandom_range(99) < 22) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.req_type <= kind;
    req.req_size <= sz;
    req.req_addr <= a;
    do @(posedge clk); while (!req.ready);
    sb.note_request(kind, sz, a);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic setup_heap(logic [31:0] b, logic [31:0] n);
    cfg_we <= 1;
    cfg_idx <= CFG_BASE;
    cfg_data <= b;
    @(posedge clk);
    sb.set_reg(CFG_BASE, b);
    cfg_idx <= CFG_BYTES;
    cfg_data <= n;
    @(posedge clk);
    sb.set_reg(CFG_BYTES, n);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_size(int top);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return $urandom();
    if (r < 13) return 32'hFFFFFFFC + $urandom_range(3);
    return $urandom_range(top, 1);
  endfunction

  task automatic random_run(int n, int alloc_pct, int top);
    int r, k;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      a = (r < 70) ? sb.pick_addr(0) : (r < 78) ? 32'd0 : (r < 86) ? sb.pick_addr(1) : $urandom();
      k = $urandom_range(99);
      if (k < alloc_pct) send(REQ_ALLOC, rand_size(top), 0);
      else if (k < alloc_pct + (95 - alloc_pct) / 2) send(REQ_FREE, $urandom(), a);
      else if (k < 95) send(REQ_RESIZE, rand_size(top), a);
      else send(2'd3, $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [31:0] p, q;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    setup_heap(32'h0, 32'd4096);
    quiet = 1;
    send(REQ_ALLOC, 0, 0);
    send(REQ_ALLOC, 1, 0);
    send(REQ_ALLOC, 5, 0);
    send(REQ_ALLOC, 32'hFFFFFFFF, 0);
    send(REQ_ALLOC, 32'd4080, 0);
    send(REQ_FREE, 0, 0);
    send(REQ_FREE, 0, 32'h123);
    send(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(REQ_RESIZE, 8, 0);
    p = sb.pick_addr(0);
    send(REQ_RESIZE, 4, p);
    send(REQ_RESIZE, 200, p);
    q = sb.pick_addr(0);
    send(REQ_RESIZE, 0, q);
    send(REQ_RESIZE, 32'hFFFFFFF0, sb.pick_addr(0));
    p = sb.pick_addr(0);
    send(REQ_FREE, 0, p);
    send(REQ_FREE, 0, p);
    send(REQ_RESIZE, 10, p);
    for (int i = 0; i < 6; i++) send(REQ_ALLOC, 4, 0);
    quiet = 0;
    drain();

    setup_heap(32'hFFFFF001, 32'hFFFFFFFF);
    hold_cycles = 400;
    random_run(450, 40, 300);
    req.valid <= 0;
    while (sb.replies.size() != 0) @(posedge clk);
    random_run(30, 40, 300);
    drain();

    setup_heap(32'h12345000, 32'd3000);
    random_run(400, 45, 200);
    drain();

    setup_heap(32'hFFFFF000, 32'd10);
    random_run(50, 50, 64);
    drain();

    setup_heap({$urandom_range(32'hFFFFF, 1), 12'h000}, $urandom_range(60000, 20000));
    random_run(400, 70, 40);
    drain();

    setup_heap(32'h0, 32'h0);
    random_run(40, 50, 64);
    drain();

    quiet = 1;
    setup_heap(32'h00400000, 32'd16384);
    random_run(100, 45, 500);
    quiet = 0;
    random_run(330, 40, 500);
    drain();

    if (sb.errors == 0 && sb.replies.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #400ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
